// ===== hw/rtl/mrbi_pkg.sv =====
package mrbi_pkg;

   localparam int MAX_CONDITIONS_DEF = 8;
   localparam int MAX_VERSIONS_DEF   = 256;

   localparam int REQ_DATA_W = 120;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;

   localparam int LEVEL_W   = 8;
   localparam int VALUE_W   = 32;
   localparam int SPAN_W    = 33;
   localparam int NUM_W     = 40;
   localparam int EXPECT_W  = 16;
   localparam int INDEX_W   = 16;
   localparam int PRODUCT_W = 17;
   localparam int BIT_CNT_W = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_UPDATE,
      ST_CLOSE
   } state_type;

endpackage

// ===== hw/rtl/multi_range_bin_index.sv =====
// multi_range_bin_index
// Resolves a set of quantized conditions into one mixed-radix version index.
// Input channel req_*: one beat per condition. tuser flags the kind of beat
// (condition or empty set) and whether animation and value are valid, tlast
// closes a set. An empty-set beat closes the set by itself.
// Result channel rsp_*: one beat per closed set carrying ok, the combined
// index and the number of versions required; nothing for other beats.
// Each condition beat runs through the check, the shift-add multiply by the
// level count and the update before the next ready; when the sample lies
// strictly inside its range and must be quantized, the serial unit also runs
// the restoring divide by the range span between multiply and update. A
// failed condition skips the arithmetic and the update. Closing a set adds the
// close state, which loads the result register; the block is ready again right
// after it. A closing beat's result is registered by the close state, which
// follows the update, or the check when the set has failed or is empty.
// A finished result waits in the output register while the next beats are
// taken; a stalled receiver only holds the block when a second set closes
// before the first result is taken.
// Reset empties the result register and clears the set accumulators.
module multi_range_bin_index
   import mrbi_pkg::*;
#(
   parameter int MAX_CONDITIONS = MAX_CONDITIONS_DEF,
   parameter int MAX_VERSIONS   = MAX_VERSIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample, range_min, range_max, level_count, expected_versions
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action, anim_valid, value_ok
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ok, version_index, required_versions, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(MAX_CONDITIONS + 1);

   state_type state_ff, state_in;

   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [PRODUCT_W-1:0] product_ff, product_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 fail_ff, fail_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 action_ff, action_in;
   logic                 anim_ff, anim_in;
   logic                 vok_ff, vok_in;
   logic [VALUE_W-1:0]   sample_ff, sample_in;
   logic [VALUE_W-1:0]   lo_ff, lo_in;
   logic [VALUE_W-1:0]   hi_ff, hi_in;
   logic [LEVEL_W-1:0]   levels_ff, levels_in;
   logic                 last_ff, last_in;
   logic [EXPECT_W-1:0]  expect_ff, expect_in;

   logic [VALUE_W-1:0]   off_ff, off_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [LEVEL_W-1:0]   fix_lvl_ff, fix_lvl_in;
   logic                 need_div_ff, need_div_in;
   logic [LEVEL_W-1:0]   lvl_sh_ff, lvl_sh_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [INDEX_W+LEVEL_W-1:0]   idx_mul_ff, idx_mul_in;
   logic [PRODUCT_W+LEVEL_W-1:0] prd_mul_ff, prd_mul_in;
   logic [SPAN_W-1:0]    rem_ff, rem_in;
   logic [LEVEL_W-1:0]   divlo_ff, divlo_in;
   logic [LEVEL_W-1:0]   quot_ff, quot_in;

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 cnt_sat;
   logic                 fail_now;
   logic                 good;
   logic [SPAN_W:0]      trial;
   logic                 trial_ge;
   logic [LEVEL_W-1:0]   lvl;
   logic [PRODUCT_W-1:0] prod_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      product_in   = product_ff;
      cnt_in       = cnt_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      action_in    = action_ff;
      anim_in      = anim_ff;
      vok_in       = vok_ff;
      sample_in    = sample_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      levels_in    = levels_ff;
      last_in      = last_ff;
      expect_in    = expect_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      fix_lvl_in   = fix_lvl_ff;
      need_div_in  = need_div_ff;
      lvl_sh_in    = lvl_sh_ff;
      bit_cnt_in   = bit_cnt_ff;
      num_in       = num_ff;
      idx_mul_in   = idx_mul_ff;
      prd_mul_in   = prd_mul_ff;
      rem_in       = rem_ff;
      divlo_in     = divlo_ff;
      quot_in      = quot_ff;

      cnt_sat   = (cnt_ff >= CNT_W'(MAX_CONDITIONS));
      fail_now  = fail_ff | cnt_sat | ~vok_ff | (levels_ff == '0);
      trial     = {rem_ff, divlo_ff[LEVEL_W-1]};
      trial_ge  = (trial >= {1'b0, span_ff});
      lvl       = need_div_ff ? quot_ff : fix_lvl_ff;
      prod_next = prd_mul_ff[PRODUCT_W-1:0];
      good      = ~fail_ff & anim_ff & (product_ff == PRODUCT_W'(expect_ff)) &
                  ({1'b0, index_ff} < product_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tuser[0];
               anim_in   = req_tuser[1];
               vok_in    = req_tuser[2];
               sample_in = req_tdata[31:0];
               lo_in     = req_tdata[63:32];
               hi_in     = req_tdata[95:64];
               levels_in = req_tdata[103:96];
               expect_in = req_tdata[119:104];
               last_in   = req_tlast;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (action_ff) begin
               index_in   = '0;
               product_in = PRODUCT_W'(1);
               cnt_in     = '0;
               fail_in    = 1'b0;
               state_in   = ST_CLOSE;
            end else begin
               cnt_in  = cnt_sat ? cnt_ff : CNT_W'(cnt_ff + 1'b1);
               fail_in = fail_now;
               if (fail_now) begin
                  state_in = last_ff ? ST_CLOSE : ST_IDLE;
               end else begin
                  off_in      = VALUE_W'(sample_ff - lo_ff);
                  span_in     = SPAN_W'({hi_ff[VALUE_W-1], hi_ff} -
                                        {lo_ff[VALUE_W-1], lo_ff} + SPAN_W'(1));
                  need_div_in = 1'b0;
                  fix_lvl_in  = '0;
                  if (levels_ff <= LEVEL_W'(1) ||
                      $signed(sample_ff) <= $signed(lo_ff)) begin
                     fix_lvl_in = '0;
                  end else if ($signed(sample_ff) >= $signed(hi_ff)) begin
                     fix_lvl_in = LEVEL_W'(levels_ff - 1'b1);
                  end else begin
                     need_div_in = 1'b1;
                  end
                  lvl_sh_in  = levels_ff;
                  bit_cnt_in = '0;
                  num_in     = '0;
                  idx_mul_in = '0;
                  prd_mul_in = '0;
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            num_in     = {num_ff[NUM_W-2:0], 1'b0} +
                         (lvl_sh_ff[LEVEL_W-1] ? NUM_W'(off_ff) : '0);
            idx_mul_in = {idx_mul_ff[INDEX_W+LEVEL_W-2:0], 1'b0} +
                         (lvl_sh_ff[LEVEL_W-1] ? (INDEX_W+LEVEL_W)'(index_ff) : '0);
            prd_mul_in = {prd_mul_ff[PRODUCT_W+LEVEL_W-2:0], 1'b0} +
                         (lvl_sh_ff[LEVEL_W-1] ? (PRODUCT_W+LEVEL_W)'(product_ff) : '0);
            lvl_sh_in  = {lvl_sh_ff[LEVEL_W-2:0], 1'b0};
            bit_cnt_in = BIT_CNT_W'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == '1) begin
               rem_in   = {1'b0, num_in[NUM_W-1:LEVEL_W]};
               divlo_in = num_in[LEVEL_W-1:0];
               quot_in  = '0;
               state_in = need_div_ff ? ST_DIV : ST_UPDATE;
            end
         end
         ST_DIV: begin
            rem_in     = trial_ge ? SPAN_W'(trial - {1'b0, span_ff}) : trial[SPAN_W-1:0];
            quot_in    = {quot_ff[LEVEL_W-2:0], trial_ge};
            divlo_in   = {divlo_ff[LEVEL_W-2:0], 1'b0};
            bit_cnt_in = BIT_CNT_W'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == '1) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            index_in   = INDEX_W'(idx_mul_ff + (INDEX_W+LEVEL_W)'(lvl));
            product_in = prod_next;
            if (prod_next > PRODUCT_W'(MAX_VERSIONS)) begin
               fail_in = 1'b1;
            end
            state_in = last_ff ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[0]    = good;
               rsp_data_in[8:1]  = good ? index_ff[7:0] : 8'd0;
               rsp_data_in[17:9] = good ? product_ff[8:0] : 9'd0;
               index_in   = '0;
               product_in = PRODUCT_W'(1);
               cnt_in     = '0;
               fail_in    = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         product_ff   <= PRODUCT_W'(1);
         cnt_ff       <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         product_ff   <= product_in;
         cnt_ff       <= cnt_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      action_ff   <= action_in;
      anim_ff     <= anim_in;
      vok_ff      <= vok_in;
      sample_ff   <= sample_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      levels_ff   <= levels_in;
      last_ff     <= last_in;
      expect_ff   <= expect_in;
      off_ff      <= off_in;
      span_ff     <= span_in;
      fix_lvl_ff  <= fix_lvl_in;
      need_div_ff <= need_div_in;
      lvl_sh_ff   <= lvl_sh_in;
      bit_cnt_ff  <= bit_cnt_in;
      num_ff      <= num_in;
      idx_mul_ff  <= idx_mul_in;
      prd_mul_ff  <= prd_mul_in;
      rem_ff      <= rem_in;
      divlo_ff    <= divlo_in;
      quot_ff     <= quot_in;
   end

endmodule

// ===== dv/tb_multi_range_bin_index.sv =====
module tb_multi_range_bin_index;
   import mrbi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1400;
   localparam int HOLD_CYCLES  = 600;

   typedef struct {
      bit        action;
      bit        anim_valid;
      bit        value_ok;
      bit [31:0] sample;
      bit [31:0] range_min;
      bit [31:0] range_max;
      bit [7:0]  level_count;
      bit        last;
      bit [15:0] expected_versions;
   } cond_beat_type;

   typedef struct {
      bit       ok;
      bit [7:0] version_index;
      bit [8:0] required_versions;
   } set_result_type;

   // running mixed-radix index and version product, one expected result per closed set
   class version_scoreboard;
      bit [15:0]      index_acc;
      bit [16:0]      product_acc;
      int unsigned    cond_count;
      bit             fail_flag;
      set_result_type pending_results[$];
      int             errors;

      function new();
         clear_set();
         errors = 0;
      endfunction

      function void clear_set();
         index_acc   = '0;
         product_acc = 17'd1;
         cond_count  = 0;
         fail_flag   = 1'b0;
      endfunction

      function int unsigned level_of(int s, int lo, int hi, int unsigned levels);
         longint span;
         longint off;
         longint q;
         if (levels <= 1 || s <= lo) return 0;
         if (s >= hi) return levels - 1;
         span = longint'(hi) - longint'(lo) + 1;
         off  = longint'(s) - longint'(lo);
         q    = off * longint'(levels) / span;
         return (q < levels) ? int'(q) : levels - 1;
      endfunction

      function void note_beat(cond_beat_type b);
         set_result_type r;
         bit             good;
         int unsigned    lvl;
         if (b.action) begin
            good = b.anim_valid && b.expected_versions == 16'd1;
            r.ok = good;
            r.version_index = '0;
            r.required_versions = good ? 9'd1 : 9'd0;
            pending_results.push_back(r);
            clear_set();
            return;
         end
         if (cond_count >= MAX_CONDITIONS_DEF) fail_flag = 1'b1;
         else cond_count++;
         if (!b.value_ok || b.level_count == 0) fail_flag = 1'b1;
         if (!fail_flag) begin
            lvl = level_of(int'(b.sample), int'(b.range_min), int'(b.range_max),
                           b.level_count);
            index_acc   = 16'(int'(index_acc) * b.level_count + lvl);
            product_acc = 17'(int'(product_acc) * b.level_count);
            if (product_acc > MAX_VERSIONS_DEF) fail_flag = 1'b1;
         end
         if (!b.last) return;
         good = !fail_flag && b.anim_valid && product_acc == b.expected_versions
                && index_acc < product_acc;
         r.ok = good;
         r.version_index = good ? index_acc[7:0] : 8'd0;
         r.required_versions = good ? product_acc[8:0] : 9'd0;
         pending_results.push_back(r);
         clear_set();
      endfunction

      task report_mismatch(string what, int got, int want);
         if (errors < 100) $display("mismatch at %0t: %s got %0d expected %0d",
                                    $realtime, what, got, want);
         errors++;
      endtask

      task check_result(bit [RSP_DATA_W-1:0] d);
         set_result_type e;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat, ok", d[0], -1);
            return;
         end
         e = pending_results.pop_front();
         if (d[0] != e.ok) report_mismatch("ok", d[0], e.ok);
         if (d[8:1] != e.version_index)
            report_mismatch("version_index", d[8:1], e.version_index);
         if (d[17:9] != e.required_versions)
            report_mismatch("required_versions", d[17:9], e.required_versions);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   version_scoreboard sb = new();
   int beats_sent = 0;
   bit calm = 1'b0;
   bit stall_request = 1'b0;
   int stall_left = 0;

   multi_range_bin_index uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      cond_beat_type b;
      if (!reset && req_tvalid && req_tready) begin
         b.sample            = req_tdata[31:0];
         b.range_min         = req_tdata[63:32];
         b.range_max         = req_tdata[95:64];
         b.level_count       = req_tdata[103:96];
         b.expected_versions = req_tdata[119:104];
         b.action            = req_tuser[0];
         b.anim_valid        = req_tuser[1];
         b.value_ok          = req_tuser[2];
         b.last              = req_tlast;
         sb.note_beat(b);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver side, with one long hold-off on request
   always @(posedge clock) begin
      if (stall_request) begin
         stall_left = HOLD_CYCLES;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 28);
      end
   end

   task automatic send_beat(cond_beat_type b);
      if (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 28);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b.expected_versions, b.level_count, b.range_max, b.range_min, b.sample};
      req_tuser  <= {b.value_ok, b.anim_valid, b.action};
      req_tlast  <= b.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_cond(input bit [31:0] s, input bit [31:0] lo, input bit [31:0] hi,
                            input bit [7:0] lc, input bit lst, input bit [15:0] ev,
                            input bit anim, input bit vok);
      cond_beat_type b;
      b = '{action: 1'b0, anim_valid: anim, value_ok: vok, sample: s, range_min: lo,
            range_max: hi, level_count: lc, last: lst, expected_versions: ev};
      send_beat(b);
   endtask

   task automatic send_empty(input bit anim, input bit [15:0] ev);
      cond_beat_type b;
      b = '{action: 1'b1, anim_valid: anim, value_ok: 1'($urandom_range(1)),
            sample: $urandom, range_min: $urandom, range_max: $urandom,
            level_count: 8'($urandom), last: 1'($urandom_range(1)),
            expected_versions: ev};
      send_beat(b);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic bit [31:0] pick_between(int lo, int hi);
      longint w;
      longint unsigned r;
      w = longint'(hi) - longint'(lo) + 1;
      r = {$urandom, $urandom};
      return 32'(longint'(lo) + longint'(r % w));
   endfunction

   // random range and a sample that mostly falls inside it
   function automatic cond_beat_type random_condition(bit [7:0] lc);
      cond_beat_type b;
      int a;
      int c;
      int t;
      longint h;
      case ($urandom_range(3))
         0: begin
            a = $urandom;
            c = $urandom;
            if (a > c) begin
               t = a;
               a = c;
               c = t;
            end
         end
         1: begin
            a = $urandom;
            h = longint'(a) + $urandom_range(1000);
            c = (h > 64'sd2147483647) ? 32'h7fff_ffff : int'(h);
         end
         2: begin
            a = int'($urandom_range(200)) - 100;
            c = a + int'($urandom_range(300));
         end
         default: begin
            a = $urandom;
            c = $urandom;
         end
      endcase
      b.action = 1'b0;
      b.anim_valid = 1'($urandom_range(1));
      b.value_ok = 1'b1;
      b.range_min = a;
      b.range_max = c;
      b.level_count = lc;
      b.last = 1'b0;
      b.expected_versions = 16'($urandom);
      case ($urandom_range(19))
         0, 1, 2, 3, 4: b.sample = $urandom;
         5, 6: b.sample = $urandom_range(1) ? a : c;
         default: b.sample = (a <= c) ? pick_between(a, c) : pick_between(c, a);
      endcase
      return b;
   endfunction

   task automatic run_good_set();
      cond_beat_type b;
      int n;
      int prod;
      int budget;
      bit [7:0] lc;
      n = ($urandom_range(3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      prod = 1;
      for (int i = 0; i < n; i++) begin
         budget = MAX_VERSIONS_DEF / prod;
         if (budget > 255) budget = 255;
         lc = (budget <= 1) ? 8'd1 : 8'($urandom_range(1, budget));
         prod = prod * lc;
         b = random_condition(lc);
         b.value_ok = ($urandom_range(49) != 0);
         b.last = (i == n - 1);
         if (b.last) begin
            b.anim_valid = ($urandom_range(19) != 0);
            b.expected_versions = ($urandom_range(9) != 0) ? 16'(prod) : 16'($urandom);
         end
         send_beat(b);
      end
   endtask

   task automatic run_broken_set();
      cond_beat_type b;
      int n;
      n = $urandom_range(1, 11);
      for (int i = 0; i < n; i++) begin
         b = random_condition(($urandom_range(3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 6)));
         b.value_ok = ($urandom_range(9) != 0);
         b.last = (i == n - 1) || ($urandom_range(15) == 0);
         if ($urandom_range(1)) b.expected_versions = 16'($urandom_range(0, 40));
         send_beat(b);
      end
   endtask

   task automatic run_abandoned_set();
      cond_beat_type b;
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         b = random_condition(8'($urandom_range(1, 4)));
         send_beat(b);
      end
      send_empty($urandom_range(3) != 0, $urandom_range(1) ? 16'd1 : 16'($urandom));
   endtask

   initial begin
      int kind;
      int random_start;
      bit held;
      bit drained;
      held = 1'b0;
      drained = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty sets
      send_empty(1'b1, 16'd1);
      send_empty(1'b1, 16'd0);
      send_empty(1'b0, 16'd1);
      // extremes of sample and range
      send_cond(32'h8000_0000, -100, 100, 8'd4, 1'b1, 16'd4, 1'b1, 1'b1);
      send_cond(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 8'd255, 1'b1, 16'd255,
                1'b1, 1'b1);
      send_cond(32'h0, 32'h8000_0000, 32'h7fff_ffff, 8'd255, 1'b1, 16'd255, 1'b1, 1'b1);
      // product right at the version limit
      send_cond(37, 0, 99, 8'd16, 1'b0, 16'd0, 1'b1, 1'b1);
      send_cond(-5, -10, 10, 8'd16, 1'b1, 16'd256, 1'b1, 1'b1);
      // product over the limit
      send_cond(50, 0, 99, 8'd16, 1'b0, 16'd0, 1'b1, 1'b1);
      send_cond(50, 0, 99, 8'd17, 1'b1, 16'd272, 1'b1, 1'b1);
      // inverted range
      send_cond(200, 100, -100, 8'd3, 1'b1, 16'd3, 1'b1, 1'b1);
      // zero levels, missing value, invalid animation, count mismatch
      send_cond(5, 0, 9, 8'd0, 1'b1, 16'd0, 1'b1, 1'b1);
      send_cond(5, 0, 9, 8'd4, 1'b1, 16'd4, 1'b1, 1'b0);
      send_cond(5, 0, 9, 8'd4, 1'b1, 16'd4, 1'b0, 1'b1);
      send_cond(5, 0, 9, 8'd5, 1'b1, 16'hffff, 1'b1, 1'b1);
      // set abandoned by an empty set
      send_cond(5, 0, 9, 8'd5, 1'b0, 16'd5, 1'b1, 1'b1);
      send_empty(1'b1, 16'd1);
      // one condition over the limit
      for (int i = 0; i <= MAX_CONDITIONS_DEF; i++)
         send_cond(i, 0, 9, 8'd1, i == MAX_CONDITIONS_DEF, 16'd1, 1'b1, 1'b1);
      wait_results_done();

      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         if (!held && beats_sent - random_start >= 300) begin
            stall_request = 1'b1;
            held = 1'b1;
         end
         if (!drained && beats_sent - random_start >= 700) begin
            wait_results_done();
            drained = 1'b1;
         end
         calm = (beats_sent - random_start >= 900) && (beats_sent - random_start < 1100);
         kind = $urandom_range(99);
         if (kind < 70) run_good_set();
         else if (kind < 85) run_broken_set();
         else if (kind < 93) send_empty($urandom_range(3) != 0,
                                        $urandom_range(1) ? 16'd1 : 16'($urandom));
         else run_abandoned_set();
      end
      calm = 1'b0;
      wait_results_done();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
